@@ hw/rtl/mse_pkg.sv @@
package mse_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	// control broadcast along the sorting chain
	typedef struct packed {
		logic ins;    // insert the new sample in order
		logic shift;  // move every cell one place toward the head
	} chain_ctrl_t;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

endpackage

@@ hw/rtl/mse_cell.sv @@
module mse_cell import mse_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  chain_ctrl_t                   ctrl,
	input  logic signed [SAMPLE_BITS-1:0] new_val,
	input  logic                          occ,
	input  logic                          prev_occ,
	input  logic                          prev_lt,
	input  logic signed [SAMPLE_BITS-1:0] prev_val,
	input  logic signed [SAMPLE_BITS-1:0] next_val,
	output logic                          lt,
	output logic signed [SAMPLE_BITS-1:0] val
);

	logic signed [SAMPLE_BITS-1:0] val_q;

	// new sample sorts before this cell's value
	assign lt  = occ && (new_val < val_q);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			// the insertion cell takes the new sample; cells above it take their neighbor's value
			if (lt || (!occ && prev_occ)) begin
				val_q <= prev_lt ? prev_val : new_val;
			end
		end else if (ctrl.shift) begin
			val_q <= next_val;
		end
	end

endmodule

@@ hw/rtl/mse_chain.sv @@
module mse_chain import mse_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                          clk,
	input  chain_ctrl_t                   ctrl,
	input  logic signed [SAMPLE_BITS-1:0] new_val,
	input  logic [CW-1:0]                 count,
	output logic signed [SAMPLE_BITS-1:0] head0,
	output logic signed [SAMPLE_BITS-1:0] head1
);

	logic signed [SAMPLE_BITS-1:0] vals [MAX_SAMPLES];
	logic [MAX_SAMPLES-1:0] occ;
	logic [MAX_SAMPLES-1:0] lt;

	genvar i;
	generate
		for (i = 0; i < MAX_SAMPLES; i++) begin : g_cell
			assign occ[i] = CW'(i) < count;

			if (i == 0) begin : g_head
				mse_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.prev_occ (1'b1),
					.prev_lt  (1'b0),
					.prev_val (new_val),
					.next_val (vals[i+1]),
					.lt       (lt[i]),
					.val      (vals[i])
				);
			end else if (i == MAX_SAMPLES - 1) begin : g_tail
				mse_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.prev_occ (occ[i-1]),
					.prev_lt  (lt[i-1]),
					.prev_val (vals[i-1]),
					.next_val (vals[i]),
					.lt       (lt[i]),
					.val      (vals[i])
				);
			end else begin : g_mid
				mse_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.new_val  (new_val),
					.occ      (occ[i]),
					.prev_occ (occ[i-1]),
					.prev_lt  (lt[i-1]),
					.prev_val (vals[i-1]),
					.next_val (vals[i+1]),
					.lt       (lt[i]),
					.val      (vals[i])
				);
			end
		end
	endgenerate

	assign head0 = vals[0];
	assign head1 = vals[1];

endmodule

@@ hw/rtl/median_select_engine.sv @@
// Samples are taken one per cycle while the engine is loading; each is put in order by the
// cell chain on entry. After the last item, the chain shifts toward its head until the median
// lies at the head (the lower middle sample for an even set), then the result is registered;
// it is held back only while the previous result is still waiting.
// No sample is taken from then until the result is stored.
// Reset clears the count, flags, state and output valid; cell contents are not reset.
module median_select_engine import mse_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                        has_sample,
	input  logic                        last,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic signed [SAMPLE_BITS:0] median_doubled,
	output logic                        empty_res,
	output logic                        overflow
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic          state_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] shift_q;
	logic          odd_q;
	logic          empty_q;
	logic          res_ovf_q;
	logic          out_valid_q;
	logic signed [SAMPLE_BITS:0] med_q;
	logic          empty_out_q;
	logic          ovf_out_q;

	logic          acc;
	logic          full;
	logic          take;
	logic [CW-1:0] n_new;
	logic          emit;
	chain_ctrl_t   ctrl;
	logic signed [SAMPLE_BITS-1:0] head0, head1;
	logic signed [SAMPLE_BITS:0]   sum;

	assign sample_ready = (state_q == ST_LOAD);
	assign acc   = sample_valid && sample_ready;
	assign full  = (count_q == CW'(MAX_SAMPLES));
	assign take  = acc && has_sample && !full;
	assign n_new = count_q + CW'(take);

	assign emit = (state_q == ST_DRAIN) && (shift_q == '0) &&
	              (!out_valid_q || result_ready);

	assign ctrl.ins   = take;
	assign ctrl.shift = (state_q == ST_DRAIN) && (shift_q != '0);

	mse_chain #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.new_val (sample),
		.count   (count_q),
		.head0   (head0),
		.head1   (head1)
	);

	assign sum = odd_q ? ({head0[SAMPLE_BITS-1], head0} + {head0[SAMPLE_BITS-1], head0})
	                   : ({head0[SAMPLE_BITS-1], head0} + {head1[SAMPLE_BITS-1], head1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			shift_q   <= '0;
			odd_q     <= 1'b0;
			empty_q   <= 1'b0;
			res_ovf_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (last) begin
							// close the set; the chain keeps the sorted samples
							state_q   <= ST_DRAIN;
							count_q   <= '0;
							ovf_q     <= 1'b0;
							shift_q   <= (n_new == '0) ? '0 : ((n_new - CW'(1)) >> 1);
							odd_q     <= n_new[0];
							empty_q   <= (n_new == '0);
							res_ovf_q <= ovf_q || (has_sample && full);
						end else begin
							count_q <= n_new;
							if (has_sample && full) begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (shift_q != '0) begin
						shift_q <= shift_q - CW'(1);
					end else if (emit) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			med_q       <= empty_q ? '0 : sum;
			empty_out_q <= empty_q;
			ovf_out_q   <= empty_q ? 1'b0 : res_ovf_q;
		end
	end

	assign result_valid   = out_valid_q;
	assign median_doubled = med_q;
	assign empty_res      = empty_out_q;
	assign overflow       = ovf_out_q;

endmodule
